[hw/rtl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

  localparam int HUE_W  = 9;
  localparam int CH_W   = 8;
  localparam int SEC_W  = 4;
  localparam int REM_W  = 6;
  localparam int NUM_W  = 14;
  localparam int PROD_W = 22;
  localparam int QUOT_W = CH_W;
  localparam int NSTAGE = 6;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int unsigned DEG_PER_SECTOR = 60;
  localparam int unsigned FULL_SCALE     = 255;
  localparam int unsigned SECTOR_SCALE   = 15300;

  // floor(x / d) ~= (x * RECIP) >> SHIFT: low by at most one for 255 and 15300, exact for 60 over 9-bit hues
  localparam int unsigned DIV60_RECIP     = 547;
  localparam int unsigned DIV60_SHIFT     = 15;
  localparam int unsigned DIV255_RECIP    = 257;
  localparam int unsigned DIV255_SHIFT    = 16;
  localparam int unsigned DIV15300_RECIP  = 17544;
  localparam int unsigned DIV15300_SHIFT  = 28;

  localparam logic [CH_W-1:0] SAT_RESET = 8'd255;
  localparam logic [CH_W-1:0] VAL_RESET = 8'd255;

  typedef enum logic {
    REG_SATURATION = 1'b0,
    REG_BRIGHTNESS = 1'b1
  } reg_idx_t;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YEL = 4'd0,
    SEC_YEL_GRN = 4'd1,
    SEC_GRN_CYN = 4'd2,
    SEC_CYN_BLU = 4'd3,
    SEC_BLU_MAG = 4'd4,
    SEC_MAG_RED = 4'd5
  } sector_t;

  typedef struct packed {
    logic load;
    logic fix;
  } cdiv_en_t;

endpackage

[hw/rtl/hsv_to_rgb_converter_top.sv]
// HSV to RGB pixel converter.
// Requests carry a 9-bit hue in degrees (hue_valid/hue_ready); each gives
// one RGB pixel on red/green/blue (rgb_valid/rgb_ready). Saturation and
// value come from two APB registers: saturation at 0x0, brightness_value
// at 0x4, both 8 bits, reset to 255. pready is tied high; reads return the
// register contents. Write registers only while no request is in flight.
// Throughput is one pixel per clock while rgb_ready is high: the six
// stages (sector split, numerators, v products, reciprocal divides by
// estimate and fixup, sector select) each take a request every cycle
// unless held from downstream. When rgb_ready is low, each stage holds
// only if the one after it is full, so bubbles get squeezed out and
// hue_ready drops only once the whole pipe is full. Synchronous reset
// clears all valid bits and sets both registers to 255; datapath
// registers are not reset.
module hsv_to_rgb_converter_top
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // hue requests
  input  logic              hue_valid,
  output logic              hue_ready,
  input  logic [HUE_W-1:0]  hue,
  // pixels
  output logic              rgb_valid,
  input  logic              rgb_ready,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue
);

  // ---------------- configuration registers ----------------
  logic [CH_W-1:0] saturation;
  logic [CH_W-1:0] brightness_value;
  reg_idx_t        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation       <= SAT_RESET;
      brightness_value <= VAL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SATURATION: saturation       <= pwdata[CH_W-1:0];
        REG_BRIGHTNESS: brightness_value <= pwdata[CH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SATURATION: prdata = DATA_W'(saturation);
      REG_BRIGHTNESS: prdata = DATA_W'(brightness_value);
    endcase
  end

  // ---------------- pipeline control ----------------
  // vld[k] marks stage k full; adv[k] lets stage k load this cycle.
  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] adv;

  always_comb begin
    adv[NSTAGE+1] = rgb_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign hue_ready = adv[1];
  assign rgb_valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= hue_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: sector and remainder ----------------
  localparam int D60_W = HUE_W + $clog2(DIV60_RECIP + 1);

  logic [D60_W-1:0] hue_scaled;
  logic [SEC_W-1:0] sec_c;
  logic [HUE_W-1:0] rem_c;
  sector_t          sec1, sec2, sec3, sec4, sec5;
  logic [REM_W-1:0] rem1;

  assign hue_scaled = D60_W'(hue) * D60_W'(DIV60_RECIP);
  assign sec_c      = SEC_W'(hue_scaled >> DIV60_SHIFT);
  assign rem_c      = hue - HUE_W'(sec_c) * HUE_W'(DEG_PER_SECTOR);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec1 <= sector_t'(sec_c);
      rem1 <= rem_c[REM_W-1:0];
    end
  end

  // ---------------- stage 2: numerators ----------------
  logic [CH_W-1:0]  num_p;
  logic [NUM_W-1:0] num_q, num_t;
  logic [REM_W-1:0] rem_inv;

  assign rem_inv = REM_W'(DEG_PER_SECTOR) - rem1;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sec2  <= sec1;
      num_p <= CH_W'(FULL_SCALE) - saturation;
      num_q <= NUM_W'(SECTOR_SCALE) - NUM_W'(saturation) * NUM_W'(rem1);
      num_t <= NUM_W'(SECTOR_SCALE) - NUM_W'(saturation) * NUM_W'(rem_inv);
    end
  end

  // ---------------- stage 3: scale by value ----------------
  logic [PROD_W-1:0] prod_p, prod_q, prod_t;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sec3   <= sec2;
      prod_p <= PROD_W'(brightness_value) * PROD_W'(num_p);
      prod_q <= PROD_W'(brightness_value) * PROD_W'(num_q);
      prod_t <= PROD_W'(brightness_value) * PROD_W'(num_t);
    end
  end

  // ---------------- stages 4-5: constant divides ----------------
  cdiv_en_t        div_en;
  logic [CH_W-1:0] p_lvl, q_lvl, t_lvl;

  assign div_en.load = adv[4];
  assign div_en.fix  = adv[5];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sec4 <= sec3;
    end
    if (adv[5]) begin
      sec5 <= sec4;
    end
  end

  hsvrgb_cdiv #(
    .DIVISOR(FULL_SCALE),
    .RECIP  (DIV255_RECIP),
    .SHIFT  (DIV255_SHIFT)
  ) u_div_p (
    .clk     (clk),
    .en      (div_en),
    .dividend(prod_p),
    .quot    (p_lvl)
  );

  hsvrgb_cdiv #(
    .DIVISOR(SECTOR_SCALE),
    .RECIP  (DIV15300_RECIP),
    .SHIFT  (DIV15300_SHIFT)
  ) u_div_q (
    .clk     (clk),
    .en      (div_en),
    .dividend(prod_q),
    .quot    (q_lvl)
  );

  hsvrgb_cdiv #(
    .DIVISOR(SECTOR_SCALE),
    .RECIP  (DIV15300_RECIP),
    .SHIFT  (DIV15300_SHIFT)
  ) u_div_t (
    .clk     (clk),
    .en      (div_en),
    .dividend(prod_t),
    .quot    (t_lvl)
  );

  // ---------------- stage 6: sector select, output register ----------------
  // Zero saturation needs no special case: p = q = t = v then.
  logic [CH_W-1:0] r_c, g_c, b_c;

  always_comb begin
    unique case (sec5)
      SEC_RED_YEL: begin r_c = brightness_value; g_c = t_lvl; b_c = p_lvl; end
      SEC_YEL_GRN: begin r_c = q_lvl; g_c = brightness_value; b_c = p_lvl; end
      SEC_GRN_CYN: begin r_c = p_lvl; g_c = brightness_value; b_c = t_lvl; end
      SEC_CYN_BLU: begin r_c = p_lvl; g_c = q_lvl; b_c = brightness_value; end
      SEC_BLU_MAG: begin r_c = t_lvl; g_c = p_lvl; b_c = brightness_value; end
      // magenta-red, plus hues of 360 and up
      default:     begin r_c = brightness_value; g_c = p_lvl; b_c = q_lvl; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      red   <= r_c;
      green <= g_c;
      blue  <= b_c;
    end
  end

endmodule

[hw/rtl/hsvrgb_cdiv.sv]
// Two-stage divide by a constant: reciprocal estimate, then one-step fixup.
module hsvrgb_cdiv
  import hsvrgb_pkg::*;
#(
  parameter int unsigned DIVISOR = SECTOR_SCALE,
  parameter int unsigned RECIP   = DIV15300_RECIP,
  parameter int unsigned SHIFT   = DIV15300_SHIFT
) (
  input  logic              clk,
  input  cdiv_en_t          en,
  input  logic [PROD_W-1:0] dividend,
  output logic [QUOT_W-1:0] quot
);

  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int MUL_W   = PROD_W + RECIP_W;

  logic [MUL_W-1:0]  est_full;
  logic [QUOT_W-1:0] est;
  logic [PROD_W-1:0] dividend_d;
  logic [PROD_W-1:0] resid;

  assign est_full = MUL_W'(dividend) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.load) begin
      est        <= QUOT_W'(est_full >> SHIFT);
      dividend_d <= dividend;
    end
  end

  assign resid = dividend_d - PROD_W'(est) * PROD_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (en.fix) begin
      if (resid >= PROD_W'(DIVISOR)) begin
        quot <= est + QUOT_W'(1);
      end else begin
        quot <= est;
      end
    end
  end

endmodule
